// File: sv/ack_pkg.sv
// ----------------------------------------------------------------------------
// ack_pkg
// Shared types and constants of the Aho-Corasick k-mer counter.
// ----------------------------------------------------------------------------
package ack_pkg;

    localparam int NODE_COUNT_DEF = 65536;
    localparam int KMER_COUNT_DEF = 16384;
    localparam int COUNT_BITS_DEF = 32;

    localparam int CMD_W   = 3;
    localparam int NODE_W  = 16;
    localparam int KMER_W  = 14;
    localparam int VAL_W   = 32;

    localparam logic [CMD_W-1:0] CMD_STREAM   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE_WR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INFO_WR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CNT_RD   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CNT_WR   = 3'd4;

    // Classified operation handed from the front to the back.
    typedef enum logic [2:0] {
        OP_STREAM,
        OP_RESET_ROOT,
        OP_EDGE_WR,
        OP_INFO_WR,
        OP_CNT_RD,
        OP_CNT_WR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              restart;
        logic [1:0]        base;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] target;
        logic [KMER_W-1:0] kid;
        logic [VAL_W-1:0]  cval;
    } work_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WAIT,
        ST_LINK_WAIT,
        ST_LEAF_WAIT,
        ST_CNT_WAIT,
        ST_CNT_WR,
        ST_RD_WAIT,
        ST_CLEAR,
        ST_DONE
    } bst_t;

endpackage

// File: sv/ack_ram.sv
// ----------------------------------------------------------------------------
// ack_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module ack_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: sv/ack_front.sv
// ----------------------------------------------------------------------------
// ack_front
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module ack_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ack_pkg::CMD_W-1:0]  cmd,
    input  logic [1:0]                 base_code,
    input  logic                       symbol_invalid,
    input  logic                       line_start,
    input  logic [ack_pkg::NODE_W-1:0] node_index,
    input  logic [ack_pkg::NODE_W-1:0] target_node,
    input  logic [ack_pkg::KMER_W-1:0] kmer_id,
    input  logic [ack_pkg::VAL_W-1:0]  count_value,
    output logic                       q_valid,
    input  logic                       q_pop,
    output ack_pkg::work_t             q_word
);
    // Two-entry queue.
    ack_pkg::work_t slot_reg [2];
    logic           rd_ptr_reg, rd_ptr_next;
    logic           wr_ptr_reg, wr_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    ack_pkg::work_t cls;
    logic           push;

    always_comb
    begin
        cls.restart = line_start;
        cls.base    = base_code;
        cls.node    = node_index;
        cls.target  = target_node;
        cls.kid     = kmer_id;
        cls.cval    = count_value;
        case (cmd)
            ack_pkg::CMD_STREAM:  cls.op = symbol_invalid ? ack_pkg::OP_RESET_ROOT
                                                           : ack_pkg::OP_STREAM;
            ack_pkg::CMD_EDGE_WR: cls.op = ack_pkg::OP_EDGE_WR;
            ack_pkg::CMD_INFO_WR: cls.op = ack_pkg::OP_INFO_WR;
            ack_pkg::CMD_CNT_RD:  cls.op = ack_pkg::OP_CNT_RD;
            ack_pkg::CMD_CNT_WR:  cls.op = ack_pkg::OP_CNT_WR;
            default:              cls.op = ack_pkg::OP_NOP;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_word   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_ptr_eq: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> rd_ptr_reg == wr_ptr_reg)
        else $error("queue pointers inconsistent");
endmodule

// File: sv/ack_back.sv
// ----------------------------------------------------------------------------
// ack_back
// Executes queued words: trie walk with suffix links, table writes and
// saturating counter updates, then holds the result for the receiver.
// ----------------------------------------------------------------------------
module ack_back #(
    parameter int NODE_COUNT = ack_pkg::NODE_COUNT_DEF,
    parameter int KMER_COUNT = ack_pkg::KMER_COUNT_DEF,
    parameter int COUNT_BITS = ack_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  ack_pkg::work_t             q_word,
    input  logic [ack_pkg::VAL_W-1:0]  ceiling,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       hit,
    output logic [ack_pkg::KMER_W-1:0] hit_id,
    output logic [ack_pkg::VAL_W-1:0]  count_out,
    output logic [ack_pkg::NODE_W-1:0] node_now
);
    localparam int NA   = $clog2(NODE_COUNT);
    localparam int CA   = NA + 2;
    localparam int KA   = $clog2(KMER_COUNT);
    localparam int WA   = (CA > KA) ? CA : KA;
    localparam int STW  = NA + 1;
    localparam int CLR_LAST = ((NODE_COUNT*4 > KMER_COUNT) ? NODE_COUNT*4 : KMER_COUNT) - 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    ack_pkg::bst_t st_reg, st_next;
    ack_pkg::work_t w_reg, w_next;
    logic [ack_pkg::NODE_W-1:0] cur_reg, cur_next;   // walk node
    logic [ack_pkg::NODE_W-1:0] node_reg, node_next; // committed current node
    logic [NA:0]                steps_reg, steps_next;
    logic [WA:0]                clr_reg, clr_next;
    logic                       hit_reg, hit_next;
    logic [ack_pkg::KMER_W-1:0] id_reg, id_next;
    logic [ack_pkg::VAL_W-1:0]  cnt_reg, cnt_next;
    logic                       ov_reg, ov_next;

    // Memory ports.
    logic                       ch_we, lk_we, lf_we, kc_we;
    logic [CA-1:0]              ch_a;
    logic [NA-1:0]              lk_a, lf_a;
    logic [KA-1:0]              kc_a;
    logic [ack_pkg::NODE_W-1:0] ch_wd, ch_rd, lk_wd, lk_rd;
    logic [ack_pkg::KMER_W-1:0] lf_wd, lf_rd;
    logic [COUNT_BITS-1:0]      kc_wd, kc_rd;

    ack_ram #(.WIDTH(ack_pkg::NODE_W), .DEPTH(NODE_COUNT*4)) u_child (
        .clk(clk), .we(ch_we), .addr(ch_a), .wdata(ch_wd), .rdata(ch_rd));
    ack_ram #(.WIDTH(ack_pkg::NODE_W), .DEPTH(NODE_COUNT)) u_link (
        .clk(clk), .we(lk_we), .addr(lk_a), .wdata(lk_wd), .rdata(lk_rd));
    ack_ram #(.WIDTH(ack_pkg::KMER_W), .DEPTH(NODE_COUNT)) u_leaf (
        .clk(clk), .we(lf_we), .addr(lf_a), .wdata(lf_wd), .rdata(lf_rd));
    ack_ram #(.WIDTH(COUNT_BITS), .DEPTH(KMER_COUNT)) u_cnt (
        .clk(clk), .we(kc_we), .addr(kc_a), .wdata(kc_wd), .rdata(kc_rd));

    logic node_ok, kid_ok, ch_ok, lk_ok, id_ok, sat;
    logic [ack_pkg::NODE_W-1:0] ch_val, lk_val;
    logic [COUNT_BITS-1:0]      inc_val;
    logic [ack_pkg::VAL_W-1:0]  kc_rd32;

    assign node_ok = ({16'd0, w_reg.node} < 32'(NODE_COUNT));
    assign kid_ok  = ({18'd0, w_reg.kid} < 32'(KMER_COUNT));
    assign ch_ok   = ({16'd0, ch_rd} < 32'(NODE_COUNT));
    assign lk_ok   = ({16'd0, lk_rd} < 32'(NODE_COUNT));
    assign id_ok   = (lf_rd != '0) && ({18'd0, lf_rd} < 32'(KMER_COUNT));
    assign ch_val  = ch_ok ? ch_rd : '0;
    assign lk_val  = lk_ok ? lk_rd : '0;
    assign kc_rd32 = ack_pkg::VAL_W'({{64{1'b0}}, kc_rd});
    // Saturation compares the stored count with the ceiling, zero-extended.
    assign sat     = ({{64{1'b0}}, kc_rd} >= {{64{1'b0}}, ceiling}) || (kc_rd == CNT_MAX);
    assign inc_val = sat ? kc_rd : kc_rd + 1'b1;

    always_comb
    begin
        st_next    = st_reg;
        w_next     = w_reg;
        cur_next   = cur_reg;
        node_next  = node_reg;
        steps_next = steps_reg;
        clr_next   = clr_reg;
        hit_next   = hit_reg;
        id_next    = id_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg;
        case (st_reg)
            ack_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (WA+1)'(CLR_LAST))
                begin
                    st_next = ack_pkg::ST_IDLE;
                end
            end
            ack_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    w_next   = q_word;
                    hit_next = 1'b0;
                    id_next  = '0;
                    cnt_next = '0;
                    case (q_word.op)
                        ack_pkg::OP_STREAM:
                        begin
                            cur_next   = q_word.restart ? '0 : node_reg;
                            steps_next = '0;
                            st_next    = ack_pkg::ST_EDGE_RD;
                        end
                        ack_pkg::OP_RESET_ROOT:
                        begin
                            node_next = '0;
                            st_next   = ack_pkg::ST_DONE;
                        end
                        ack_pkg::OP_CNT_RD:
                        begin
                            id_next = q_word.kid;
                            st_next = ack_pkg::ST_RD_WAIT;
                        end
                        ack_pkg::OP_CNT_WR:
                        begin
                            id_next = q_word.kid;
                            st_next = ack_pkg::ST_DONE;
                            if ({18'd0, q_word.kid} < 32'(KMER_COUNT))
                            begin
                                cnt_next = ack_pkg::VAL_W'({{64{1'b0}},
                                    COUNT_BITS'({{64{1'b0}}, q_word.cval})});
                            end
                        end
                        default: st_next = ack_pkg::ST_DONE;
                    endcase
                end
            end
            ack_pkg::ST_EDGE_RD: st_next = ack_pkg::ST_EDGE_WAIT;
            ack_pkg::ST_EDGE_WAIT:
            begin
                // Child data of cur_reg and its link are valid now.
                if (ch_val != '0)
                begin
                    node_next = ch_val;
                    st_next   = ack_pkg::ST_LEAF_WAIT;
                end
                else if (cur_reg == '0 || steps_reg == STW'(NODE_COUNT))
                begin
                    node_next = '0;
                    st_next   = ack_pkg::ST_DONE;
                end
                else
                begin
                    cur_next   = lk_val;
                    steps_next = steps_reg + 1'b1;
                    st_next    = ack_pkg::ST_EDGE_RD;
                end
            end
            ack_pkg::ST_LEAF_WAIT: st_next = ack_pkg::ST_LINK_WAIT;
            ack_pkg::ST_LINK_WAIT:
            begin
                if (id_ok)
                begin
                    id_next  = lf_rd;
                    hit_next = 1'b1;
                    st_next  = ack_pkg::ST_CNT_WAIT;
                end
                else
                begin
                    st_next = ack_pkg::ST_DONE;
                end
            end
            ack_pkg::ST_CNT_WAIT: st_next = ack_pkg::ST_CNT_WR;
            ack_pkg::ST_CNT_WR:
            begin
                cnt_next = ack_pkg::VAL_W'({{64{1'b0}}, inc_val});
                st_next  = ack_pkg::ST_DONE;
            end
            ack_pkg::ST_RD_WAIT:
            begin
                cnt_next = kid_ok ? kc_rd32 : '0;
                st_next  = ack_pkg::ST_DONE;
            end
            ack_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    st_next = ack_pkg::ST_IDLE;
                end
            end
            default: st_next = ack_pkg::ST_IDLE;
        endcase
        ov_next = 1'b0;
    end

    // Memory control.
    always_comb
    begin
        ch_we = 1'b0; lk_we = 1'b0; lf_we = 1'b0; kc_we = 1'b0;
        ch_a  = CA'({cur_reg, w_reg.base});
        lk_a  = NA'(cur_reg);
        lf_a  = NA'(node_reg);
        kc_a  = KA'(id_reg);
        ch_wd = w_reg.target;
        lk_wd = w_reg.target;
        lf_wd = w_reg.kid;
        kc_wd = inc_val;
        case (st_reg)
            ack_pkg::ST_CLEAR:
            begin
                ch_we = 1'b1;
                ch_a  = CA'(clr_reg);
                ch_wd = '0;
                lk_we = 1'b1;
                lk_a  = NA'(clr_reg);
                lk_wd = '0;
                lf_we = 1'b1;
                lf_a  = NA'(clr_reg);
                lf_wd = '0;
                kc_we = 1'b1;
                kc_a  = KA'(clr_reg);
                kc_wd = '0;
            end
            ack_pkg::ST_IDLE:
            begin
                kc_a = KA'(q_word.kid);
                if (q_valid && q_word.op == ack_pkg::OP_EDGE_WR &&
                    ({16'd0, q_word.node} < 32'(NODE_COUNT)))
                begin
                    ch_we = 1'b1;
                    ch_a  = CA'({q_word.node, q_word.base});
                    ch_wd = q_word.target;
                end
                if (q_valid && q_word.op == ack_pkg::OP_INFO_WR &&
                    ({16'd0, q_word.node} < 32'(NODE_COUNT)))
                begin
                    lk_we = 1'b1;
                    lk_a  = NA'(q_word.node);
                    lk_wd = q_word.target;
                    lf_we = 1'b1;
                    lf_a  = NA'(q_word.node);
                    lf_wd = q_word.kid;
                end
                if (q_valid && q_word.op == ack_pkg::OP_CNT_WR &&
                    ({18'd0, q_word.kid} < 32'(KMER_COUNT)))
                begin
                    kc_we = 1'b1;
                    kc_wd = COUNT_BITS'({{64{1'b0}}, q_word.cval});
                end
            end
            ack_pkg::ST_CNT_WR: kc_we = 1'b1;
            default: ;
        endcase
    end

    assign q_pop     = (st_reg == ack_pkg::ST_IDLE) && q_valid;
    assign out_valid = (st_reg == ack_pkg::ST_DONE);
    assign hit       = hit_reg;
    assign hit_id    = id_reg;
    assign count_out = cnt_reg;
    assign node_now  = node_reg;

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        cur_reg <= cur_next;
        id_reg  <= id_next;
        cnt_reg <= cnt_next;
        ov_reg  <= ov_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ack_pkg::ST_CLEAR;
            node_reg  <= '0;
            steps_reg <= '0;
            clr_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            node_reg  <= node_next;
            steps_reg <= steps_next;
            clr_reg   <= clr_next;
            hit_reg   <= hit_next;
        end
    end

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count_out) && $stable(hit))
        else $error("result changed while stalled");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !out_valid || $past(q_word.op) != ack_pkg::OP_STREAM)
        else $error("walk finished too early");
    a_hit_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> node_now != '0 && hit_id != '0)
        else $error("hit at root");
    a_no_ov: assert property (@(posedge clk) disable iff (!rst_n)
        !ov_reg) else $error("overflow flag set");
endmodule

// File: sv/aho_corasick_kmer_counter.sv
// ----------------------------------------------------------------------------
// aho_corasick_kmer_counter
// Aho-Corasick trie walker that counts DNA k-mers with saturating counters.
// ----------------------------------------------------------------------------
// Usage: input words arrive on in_valid/in_ready with the command fields; each
// accepted word gives exactly one result word on out_valid/out_ready. A
// front stage classifies words into a two-word queue; the back end runs them.
// The count ceiling is written through cfg_we/cfg_data; the user must write
// it only while the block is idle, the block does not enforce this. Per word:
// table writes, invalid symbols, unknown commands and counter writes go from
// idle straight to the result; a counter read waits for a counter table read; a
// stream symbol reads the child and link of the walk node and follows links
// on a miss; a found edge adds a leaf lookup, and a hit then adds a counter
// read-modify-write. Each trie step is one registered read of the child table.
// After reset all tables are cleared, one entry per cycle over the larger
// of 4*NODE_COUNT and KMER_COUNT addresses, while in_ready may still take two
// words into the queue. A stalled receiver holds the result; the queue then
// fills and in_ready drops.
// ----------------------------------------------------------------------------
module aho_corasick_kmer_counter #(
    parameter int NODE_COUNT = ack_pkg::NODE_COUNT_DEF,
    parameter int KMER_COUNT = ack_pkg::KMER_COUNT_DEF,
    parameter int COUNT_BITS = ack_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ack_pkg::VAL_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ack_pkg::CMD_W-1:0]  cmd,
    input  logic [1:0]                 base_code,
    input  logic                       symbol_invalid,
    input  logic                       line_start,
    input  logic [ack_pkg::NODE_W-1:0] node_index,
    input  logic [ack_pkg::NODE_W-1:0] target_node,
    input  logic [ack_pkg::KMER_W-1:0] kmer_id,
    input  logic [ack_pkg::VAL_W-1:0]  count_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       hit,
    output logic [ack_pkg::KMER_W-1:0] hit_id,
    output logic [ack_pkg::VAL_W-1:0]  count_out,
    output logic [ack_pkg::NODE_W-1:0] node_now
);
    logic [ack_pkg::VAL_W-1:0] ceiling_reg;
    logic                      q_valid, q_pop;
    ack_pkg::work_t            q_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg <= '1;
        end
        else if (cfg_we)
        begin
            ceiling_reg <= cfg_data;
        end
    end

    ack_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .base_code(base_code), .symbol_invalid(symbol_invalid),
        .line_start(line_start), .node_index(node_index),
        .target_node(target_node), .kmer_id(kmer_id),
        .count_value(count_value), .q_valid(q_valid), .q_pop(q_pop),
        .q_word(q_word));

    ack_back #(.NODE_COUNT(NODE_COUNT), .KMER_COUNT(KMER_COUNT),
               .COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_word(q_word), .ceiling(ceiling_reg), .out_valid(out_valid),
        .out_ready(out_ready), .hit(hit), .hit_id(hit_id),
        .count_out(count_out), .node_now(node_now));
endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the Aho-Corasick k-mer counter against its own trie-walk predictor.
// Words are built in an initial block, driven from a queue and checked one by
// one against predicted results. The run covers directed corner cases, then
// several random tries streamed under different idle patterns and ceilings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES       = ack_pkg::NODE_COUNT_DEF;
    localparam int KMERS       = ack_pkg::KMER_COUNT_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 40;
    localparam logic [ack_pkg::CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [ack_pkg::CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

    typedef struct packed {
        logic [ack_pkg::CMD_W-1:0]  cmd;
        logic [1:0]                 base;
        logic                       inv;
        logic                       ls;
        logic [ack_pkg::NODE_W-1:0] node;
        logic [ack_pkg::NODE_W-1:0] target;
        logic [ack_pkg::KMER_W-1:0] kid;
        logic [ack_pkg::VAL_W-1:0]  cval;
    } word_t;

    typedef struct packed {
        logic                       hit;
        logic [ack_pkg::KMER_W-1:0] hit_id;
        logic [ack_pkg::VAL_W-1:0]  count;
        logic [ack_pkg::NODE_W-1:0] node;
    } match_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [ack_pkg::VAL_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic [ack_pkg::KMER_W-1:0] hit_id;
    logic [ack_pkg::VAL_W-1:0] count_out;
    logic [ack_pkg::NODE_W-1:0] node_now;
    word_t cur = '0;

    // Predictor state.
    bit [ack_pkg::NODE_W-1:0] child_tbl [0:NODES*4-1];
    bit [ack_pkg::NODE_W-1:0] link_tbl [0:NODES-1];
    bit [ack_pkg::KMER_W-1:0] leaf_tbl [0:NODES-1];
    bit [ack_pkg::VAL_W-1:0]  kmer_cnt [0:KMERS-1];
    bit [ack_pkg::NODE_W-1:0] walk_node = '0;
    bit [ack_pkg::VAL_W-1:0]  ceiling = 32'hFFFF_FFFF;

    word_t  word_q [$];
    match_t match_q [$];
    bit     in_fire = 1'b0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     errors = 0;
    int     words_in = 0;
    int     results_seen = 0;
    int     hits_seen = 0;
    longint cycles = 0;

    aho_corasick_kmer_counter dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cur.cmd), .base_code(cur.base), .symbol_invalid(cur.inv),
        .line_start(cur.ls), .node_index(cur.node), .target_node(cur.target),
        .kmer_id(cur.kid), .count_value(cur.cval),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .hit_id(hit_id), .count_out(count_out), .node_now(node_now)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit [ack_pkg::NODE_W-1:0] child_of(bit [ack_pkg::NODE_W-1:0] n,
                                                          bit [1:0] b);
        return child_tbl[{n, b}];
    endfunction

    // Walks the trie for one streamed base; follows suffix links on a miss.
    function automatic match_t step_trie(bit [1:0] b);
        match_t r;
        bit [ack_pkg::NODE_W-1:0] n;
        bit [ack_pkg::NODE_W-1:0] nxt;
        int steps;
        bit [ack_pkg::KMER_W-1:0] id;
        r = '0;
        n = walk_node;
        nxt = child_of(n, b);
        steps = 0;
        while (nxt == 0 && n != 0 && steps < NODES)
        begin
            n = link_tbl[n];
            nxt = child_of(n, b);
            steps++;
        end
        walk_node = nxt;
        if (nxt != 0)
        begin
            id = leaf_tbl[nxt];
            if (id != 0)
            begin
                if (kmer_cnt[id] < ceiling)
                    kmer_cnt[id]++;
                r.hit = 1'b1;
                r.hit_id = id;
                r.count = kmer_cnt[id];
            end
        end
        return r;
    endfunction

    function automatic match_t predict_match(word_t w);
        match_t r;
        r = '0;
        case (w.cmd)
            ack_pkg::CMD_STREAM:
            begin
                if (w.inv)
                    walk_node = '0;
                else
                begin
                    if (w.ls)
                        walk_node = '0;
                    r = step_trie(w.base);
                end
            end
            ack_pkg::CMD_EDGE_WR: child_tbl[{w.node, w.base}] = w.target;
            ack_pkg::CMD_INFO_WR:
            begin
                link_tbl[w.node] = w.target;
                leaf_tbl[w.node] = w.kid;
            end
            ack_pkg::CMD_CNT_RD:
            begin
                r.hit_id = w.kid;
                r.count = kmer_cnt[w.kid];
            end
            ack_pkg::CMD_CNT_WR:
            begin
                kmer_cnt[w.kid] = w.cval;
                r.hit_id = w.kid;
                r.count = w.cval;
            end
            default: ;
        endcase
        r.node = walk_node;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [ack_pkg::VAL_W-1:0] got,
                                   logic [ack_pkg::VAL_W-1:0] want);
        errors++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Driver: a word stays on the port until it is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (word_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cur <= word_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: predicts on every accepted word and checks every result word.
    always @(posedge clk)
    begin
        match_t want;
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
        begin
            match_q.push_back(predict_match(cur));
            words_in++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (hit)
                hits_seen++;
            if (match_q.size() == 0)
                report_mismatch("result with nothing pending", '0, '0);
            else
            begin
                want = match_q.pop_front();
                if (hit !== want.hit)
                    report_mismatch("hit", ack_pkg::VAL_W'(hit), ack_pkg::VAL_W'(want.hit));
                if (hit_id !== want.hit_id)
                    report_mismatch("hit_id", ack_pkg::VAL_W'(hit_id),
                                    ack_pkg::VAL_W'(want.hit_id));
                if (count_out !== want.count)
                    report_mismatch("count_out", count_out, want.count);
                if (node_now !== want.node)
                    report_mismatch("node_now", ack_pkg::VAL_W'(node_now),
                                    ack_pkg::VAL_W'(want.node));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, match_q.size());
            $display("** aho_corasick_kmer_counter: FAILED **");
            $finish;
        end
    end

    task automatic add_word(logic [ack_pkg::CMD_W-1:0] c, logic [1:0] b, logic inv, logic ls,
                            logic [ack_pkg::NODE_W-1:0] n, logic [ack_pkg::NODE_W-1:0] t,
                            logic [ack_pkg::KMER_W-1:0] k, logic [ack_pkg::VAL_W-1:0] v);
        word_t w;
        w.cmd = c; w.base = b; w.inv = inv; w.ls = ls;
        w.node = n; w.target = t; w.kid = k; w.cval = v;
        word_q.push_back(w);
    endtask

    task automatic drain();
        while (word_q.size() > 0 || in_valid || match_q.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_ceiling(logic [ack_pkg::VAL_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        ceiling = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Builds a small random trie, then streams over it with some host traffic
    // and noise. Suffix links always point to a lower node, so walks end.
    task automatic random_phase(int sidle, int rstall, logic [ack_pkg::VAL_W-1:0] ceil,
                                int n_words);
        int nn;
        int r;
        logic [ack_pkg::NODE_W-1:0] n;
        logic [ack_pkg::CMD_W-1:0] c;
        drain();
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        set_ceiling(ceil);
        nn = $urandom_range(3, 12);
        for (int i = 0; i <= nn; i++)
            for (int b = 0; b < 4; b++)
                add_word(ack_pkg::CMD_EDGE_WR, 2'(b), 1'($urandom), 1'($urandom),
                         ack_pkg::NODE_W'(i),
                         ack_pkg::NODE_W'(($urandom_range(0, 99) < 60) ?
                                          $urandom_range(1, nn) : 0),
                         ack_pkg::KMER_W'($urandom), $urandom);
        for (int i = 1; i <= nn; i++)
        begin
            r = $urandom_range(0, 99);
            add_word(ack_pkg::CMD_INFO_WR, 2'($urandom), 1'($urandom), 1'($urandom),
                     ack_pkg::NODE_W'(i),
                     ack_pkg::NODE_W'((i == 1) ? 0 : $urandom_range(0, i - 1)),
                     ack_pkg::KMER_W'((r < 35) ? $urandom_range(1, 15)
                                               : ((r < 40) ? 16383 : 0)),
                     $urandom);
        end
        for (int i = 0; i < n_words; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                add_word(ack_pkg::CMD_STREAM, 2'($urandom), $urandom_range(0, 99) < 4,
                         $urandom_range(0, 99) < 6, ack_pkg::NODE_W'($urandom),
                         ack_pkg::NODE_W'($urandom), ack_pkg::KMER_W'($urandom), $urandom);
            else if (r < 88)
                add_word(ack_pkg::CMD_CNT_RD, 2'($urandom), 1'($urandom), 1'($urandom),
                         ack_pkg::NODE_W'($urandom), ack_pkg::NODE_W'($urandom),
                         ack_pkg::KMER_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                      : $urandom_range(0, 15)),
                         $urandom);
            else if (r < 94)
                add_word(ack_pkg::CMD_CNT_WR, 2'($urandom), 1'($urandom), 1'($urandom),
                         ack_pkg::NODE_W'($urandom), ack_pkg::NODE_W'($urandom),
                         ack_pkg::KMER_W'($urandom_range(1, 15)),
                         $urandom_range(0, 1) ? ceil - $urandom_range(0, 2) : $urandom);
            else
            begin
                c = ack_pkg::CMD_W'($urandom_range(0, 7));
                n = ack_pkg::NODE_W'($urandom);
                add_word(c, 2'($urandom), 1'($urandom), 1'($urandom), n,
                         (c == ack_pkg::CMD_INFO_WR) ?
                             ((n == 0) ? '0 : ack_pkg::NODE_W'($urandom_range(0, n - 1)))
                           : ack_pkg::NODE_W'($urandom),
                         ack_pkg::KMER_W'($urandom), $urandom);
            end
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: saturation at the counter width, line starts,
        // invalid symbols, unknown commands, the ignored root link, suffix
        // walks and a link cycle.
        add_word(ack_pkg::CMD_EDGE_WR, 2'd0, 0, 0, 16'd0, 16'd1, 0, 0);
        add_word(ack_pkg::CMD_INFO_WR, 2'd0, 0, 0, 16'd1, 16'd0, 14'h3FFF, 0);
        add_word(ack_pkg::CMD_STREAM, 2'd0, 0, 0, 0, 0, 0, 0);
        add_word(ack_pkg::CMD_CNT_WR, 2'd0, 0, 0, 0, 0, 14'h3FFF, 32'hFFFF_FFFF);
        add_word(ack_pkg::CMD_STREAM, 2'd0, 0, 1, 0, 0, 0, 0);
        add_word(ack_pkg::CMD_CNT_RD, 2'd0, 0, 0, 0, 0, 14'h3FFF, 0);
        add_word(ack_pkg::CMD_STREAM, 2'd0, 1, 1, 0, 0, 0, 0);
        add_word(CMD_UNKNOWN_HI, 2'd3, 1, 1, 16'hFFFF, 16'hFFFF, 14'h3FFF, 32'hFFFF_FFFF);
        add_word(CMD_UNKNOWN_LO, 2'd0, 0, 0, 0, 0, 0, 0);
        add_word(ack_pkg::CMD_INFO_WR, 2'd0, 0, 0, 16'd0, 16'd5, 0, 0);
        add_word(ack_pkg::CMD_STREAM, 2'd2, 0, 0, 0, 0, 0, 0);
        add_word(ack_pkg::CMD_EDGE_WR, 2'd3, 0, 0, 16'd1, 16'hFFFF, 0, 0);
        add_word(ack_pkg::CMD_INFO_WR, 2'd0, 0, 0, 16'hFFFF, 16'd1, 14'd2, 0);
        add_word(ack_pkg::CMD_STREAM, 2'd0, 0, 0, 0, 0, 0, 0);
        add_word(ack_pkg::CMD_STREAM, 2'd3, 0, 0, 0, 0, 0, 0);
        add_word(ack_pkg::CMD_STREAM, 2'd0, 0, 0, 0, 0, 0, 0);
        add_word(ack_pkg::CMD_EDGE_WR, 2'd1, 0, 0, 16'd0, 16'd2, 0, 0);
        add_word(ack_pkg::CMD_INFO_WR, 2'd0, 0, 0, 16'd2, 16'd3, 0, 0);
        add_word(ack_pkg::CMD_INFO_WR, 2'd0, 0, 0, 16'd3, 16'd2, 0, 0);
        add_word(ack_pkg::CMD_STREAM, 2'd1, 0, 1, 0, 0, 0, 0);
        // Nodes 2 and 3 link to each other: the walk gives up at the root.
        add_word(ack_pkg::CMD_STREAM, 2'd2, 0, 0, 0, 0, 0, 0);
        add_word(ack_pkg::CMD_CNT_RD, 2'd0, 0, 0, 0, 0, 14'd0, 0);
        add_word(ack_pkg::CMD_CNT_WR, 2'd0, 0, 0, 0, 0, 14'd0, 32'h1234_5678);

        random_phase(0, 0, 32'hFFFF_FFFF, 170);
        random_phase(75, 0, 32'd1, 170);
        random_phase(0, 75, 32'd3, 170);
        random_phase(25, 25, 32'hFFFF_FFFE, 170);
        random_phase(0, 0, $urandom_range(2, 40), 170);
        drain();

        $display("%0d words sent over five random tries and a directed set,", words_in);
        $display("%0d results checked, %0d of them k-mer hits", results_seen, hits_seen);
        if (errors == 0)
            $display("** aho_corasick_kmer_counter: PASSED **");
        else
            $display("** aho_corasick_kmer_counter: FAILED **");
        $finish;
    end
endmodule

// File: sim.f
sv/ack_pkg.sv
sv/ack_ram.sv
sv/ack_front.sv
sv/ack_back.sv
sv/aho_corasick_kmer_counter.sv
verif/testbench.sv
